FILE: rtl/wffs_pkg.sv
// Shared types, codes and helpers for the weighted five-level FIFO scheduler.
`default_nettype none
package wffs_pkg;

  localparam int NUM_LEVELS = 5;
  localparam int LEVEL_W    = 3;
  localparam int WEIGHT_W   = 14;
  localparam int SLICE_W    = 64;
  localparam int BUDGET_W   = 5;
  localparam int PROBE_W    = 3;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 64'd20000000;

  // Weight thresholds for the level classifier
  localparam logic [WEIGHT_W-1:0] W_LVL0_MAX = 14'd25;
  localparam logic [WEIGHT_W-1:0] W_LVL1_MAX = 14'd50;
  localparam logic [WEIGHT_W-1:0] W_LVL2_LIM = 14'd200;
  localparam logic [WEIGHT_W-1:0] W_LVL3_LIM = 14'd400;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DISP = 2'd1,
    MODE_CMP  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OC_QUEUED   = 3'd0,
    OC_LOCAL    = 3'd1,
    OC_REENQ    = 3'd2,
    OC_OVERFLOW = 3'd3,
    OC_DISP     = 3'd4,
    OC_NONE     = 3'd5,
    OC_CMP      = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_PROBE,
    S_POP,
    S_NONE,
    S_CMP_A,
    S_CMP_B
  } state_t;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 3'd4;

  // Map a task weight to its FIFO level
  function automatic logic [LEVEL_W-1:0] level_of(input logic [WEIGHT_W-1:0] w);
    logic [LEVEL_W-1:0] lv;
    if (w <= W_LVL0_MAX)      lv = 3'd0;
    else if (w <= W_LVL1_MAX) lv = 3'd1;
    else if (w < W_LVL2_LIM)  lv = 3'd2;
    else if (w < W_LVL3_LIM)  lv = 3'd3;
    else                      lv = TOP_LEVEL;
    return lv;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/wffs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wffs_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 20480
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wffs_dist.sv
// Scaled queue distance unit, shared by both compare operands.
`default_nettype none
module wffs_dist #(
  parameter int SEQ_BITS = 32
) (
  input  wire logic [SEQ_BITS-1:0]              seq,
  input  wire logic [SEQ_BITS-1:0]              head,
  input  wire logic [wffs_pkg::LEVEL_W-1:0]     lv,
  output logic                                  neg,
  output logic      [SEQ_BITS+3:0]              mag
);
  import wffs_pkg::*;

  logic [SEQ_BITS-1:0] d;
  logic [SEQ_BITS-1:0] m;
  logic [2:0]          s;

  // Signed distance from head, magnitude shifted by level-dependent amount
  always_comb begin
    d   = seq - head;
    neg = d[SEQ_BITS-1];
    m   = neg ? (~d + 1'b1) : d;
    s   = neg ? lv : (TOP_LEVEL - lv);
    mag = {4'b0, m} << s;
  end

endmodule
`default_nettype wire

FILE: rtl/weighted_five_fifo_scheduler.sv
// Top level: five-level weighted FIFO scheduler with its control sequencer.
//
//  channel | direction | handshake            | contents
//  in_     | slave     | in_tvalid/in_tready  | tuser mode, tdata task fields
//  out_    | master    | out_tvalid/out_tready| tuser outcome, tdata result
//  cfg_    | slave     | cfg_valid/cfg_ready  | slice_length
//
// Dispatch makes one probe per cycle, up to five, and takes its result from
// the registered store read.
// The block takes one item at a time; in_tready is high only when idle.
// A result waiting in the output register holds the sequencer at its last
// step. Reset is synchronous; the FIFO store needs no clearing pass.
`default_nettype none
module weighted_five_fifo_scheduler #(
  parameter int FIFO_DEPTH = 4096,
  parameter int SEQ_BITS   = 32,
  parameter int PID_BITS   = 22
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // tuser: mode
  input  wire logic [1:0] in_tuser,
  // tdata: pid, weight, to_local, reenqueue, seq_a, weight_b, seq_b, zero pad
  input  wire logic [((PID_BITS+2*SEQ_BITS+30+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // tuser: outcome
  output logic [2:0] out_tuser,
  // tdata: out_pid, level, seq_out, slice_out, a_before_b, zero pad
  output logic [((PID_BITS+SEQ_BITS+68+7)/8)*8-1:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data
);
  import wffs_pkg::*;

  localparam int IN_W   = ((PID_BITS+2*SEQ_BITS+30+7)/8)*8;
  localparam int OUT_W  = ((PID_BITS+SEQ_BITS+68+7)/8)*8;
  localparam int OUT_F  = PID_BITS+SEQ_BITS+68;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH+1);
  localparam int RAM_D  = NUM_LEVELS*FIFO_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);
  localparam int WORD_W = PID_BITS+SEQ_BITS;
  // input field offsets
  localparam int O_W    = PID_BITS;
  localparam int O_LOC  = O_W+WEIGHT_W;
  localparam int O_RE   = O_LOC+1;
  localparam int O_SA   = O_RE+1;
  localparam int O_WB   = O_SA+SEQ_BITS;
  localparam int O_SB   = O_WB+WEIGHT_W;

  state_t state_r, state_nxt;

  // latched input item
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [WEIGHT_W-1:0] wa_r, wa_nxt, wb_r, wb_nxt;
  logic                loc_r, loc_nxt, reenq_r, reenq_nxt;
  logic [SEQ_BITS-1:0] sa_r, sa_nxt, sb_r, sb_nxt;

  // scheduler state
  logic [SLICE_W-1:0]  slice_r, slice_nxt;
  logic [PTR_W-1:0]    head_ptr_r [NUM_LEVELS];
  logic [PTR_W-1:0]    head_ptr_nxt [NUM_LEVELS];
  logic [FILL_W-1:0]   fill_r [NUM_LEVELS];
  logic [FILL_W-1:0]   fill_nxt [NUM_LEVELS];
  logic [SEQ_BITS-1:0] tail_seq_r [NUM_LEVELS];
  logic [SEQ_BITS-1:0] tail_seq_nxt [NUM_LEVELS];
  logic [SEQ_BITS-1:0] head_seq_r [NUM_LEVELS];
  logic [SEQ_BITS-1:0] head_seq_nxt [NUM_LEVELS];
  logic [LEVEL_W-1:0]  cursor_r, cursor_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [PROBE_W-1:0]  probe_r, probe_nxt;
  logic [LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic                neg_a_r, neg_a_nxt;
  logic [SEQ_BITS+3:0] mag_a_r, mag_a_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          oc_r, oc_nxt;
  logic [PID_BITS-1:0] opid_r, opid_nxt;
  logic [LEVEL_W-1:0]  olvl_r, olvl_nxt;
  logic [SEQ_BITS-1:0] oseq_r, oseq_nxt;
  logic [SLICE_W-1:0]  oslice_r, oslice_nxt;
  logic                obefore_r, obefore_nxt;

  // store and distance unit connections
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [SEQ_BITS-1:0] d_seq, d_head;
  logic [LEVEL_W-1:0]  d_lv;
  logic                d_neg;
  logic [SEQ_BITS+3:0] d_mag;

  wffs_ram #(.WIDTH(WORD_W), .DEPTH(RAM_D)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  wffs_dist #(.SEQ_BITS(SEQ_BITS)) u_dist (
    .seq(d_seq), .head(d_head), .lv(d_lv), .neg(d_neg), .mag(d_mag)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = oc_r;
  assign out_tdata  = {{(OUT_W-OUT_F){1'b0}}, obefore_r, oslice_r, oseq_r, olvl_r, opid_r};

  // Distance unit operand select: task a first, then task b
  always_comb begin
    if (state_r == S_CMP_B) begin
      d_lv  = level_of(wb_r);
      d_seq = sb_r;
    end else begin
      d_lv  = level_of(wa_r);
      d_seq = sa_r;
    end
    d_head = head_seq_r[d_lv];
  end

  // Sequencer: next state, state updates and result
  always_comb begin
    logic                out_free;
    logic [LEVEL_W-1:0]  lv;
    logic [LEVEL_W-1:0]  cl;
    logic [BUDGET_W-1:0] cb;
    logic [PTR_W:0]      pos;
    logic                gt, lt;

    state_nxt    = state_r;
    pid_nxt      = pid_r;
    wa_nxt       = wa_r;
    wb_nxt       = wb_r;
    loc_nxt      = loc_r;
    reenq_nxt    = reenq_r;
    sa_nxt       = sa_r;
    sb_nxt       = sb_r;
    slice_nxt    = slice_r;
    head_ptr_nxt = head_ptr_r;
    fill_nxt     = fill_r;
    tail_seq_nxt = tail_seq_r;
    head_seq_nxt = head_seq_r;
    cursor_nxt   = cursor_r;
    budget_nxt   = budget_r;
    probe_nxt    = probe_r;
    lvl_nxt      = lvl_r;
    neg_a_nxt    = neg_a_r;
    mag_a_nxt    = mag_a_r;
    out_valid_nxt = out_valid_r;
    oc_nxt       = oc_r;
    opid_nxt     = opid_r;
    olvl_nxt     = olvl_r;
    oseq_nxt     = oseq_r;
    oslice_nxt   = oslice_r;
    obefore_nxt  = obefore_r;
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    lv    = level_of(wa_r);
    cl    = '0;
    cb    = '0;
    pos   = '0;
    gt    = 1'b0;
    lt    = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    out_free = !out_valid_r || out_tready;

    if (cfg_valid) begin
      slice_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pid_nxt   = in_tdata[PID_BITS-1:0];
          wa_nxt    = in_tdata[O_W +: WEIGHT_W];
          loc_nxt   = in_tdata[O_LOC];
          reenq_nxt = in_tdata[O_RE];
          sa_nxt    = in_tdata[O_SA +: SEQ_BITS];
          wb_nxt    = in_tdata[O_WB +: WEIGHT_W];
          sb_nxt    = in_tdata[O_SB +: SEQ_BITS];
          probe_nxt = '0;
          unique case (mode_t'(in_tuser))
            MODE_ENQ:  state_nxt = S_ENQ;
            MODE_DISP: state_nxt = S_PROBE;
            MODE_CMP:  state_nxt = S_CMP_A;
            default:   state_nxt = S_NONE;
          endcase
        end
      end

      S_ENQ: begin
        if (out_free) begin
          tail_seq_nxt[lv] = tail_seq_r[lv] + 1'b1;
          out_valid_nxt = 1'b1;
          opid_nxt    = pid_r;
          olvl_nxt    = lv;
          oseq_nxt    = tail_seq_r[lv];
          obefore_nxt = 1'b0;
          oslice_nxt  = '0;
          if (loc_r) begin
            oc_nxt     = OC_LOCAL;
            oslice_nxt = slice_r;
          end else if (reenq_r) begin
            oc_nxt = OC_REENQ;
          end else if (fill_r[lv] >= FILL_W'(FIFO_DEPTH)) begin
            oc_nxt     = OC_OVERFLOW;
            oslice_nxt = slice_r;
          end else begin
            // push at head + fill, wrapped once
            pos = {1'b0, head_ptr_r[lv]} + (PTR_W+1)'(fill_r[lv]);
            if (pos >= (PTR_W+1)'(FIFO_DEPTH)) begin
              pos = pos - (PTR_W+1)'(FIFO_DEPTH);
            end
            we    = 1'b1;
            waddr = ADDR_W'(lv) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(pos[PTR_W-1:0]);
            wdata = {tail_seq_r[lv], pid_r};
            fill_nxt[lv] = fill_r[lv] + 1'b1;
            oc_nxt = OC_QUEUED;
          end
          state_nxt = S_IDLE;
        end
      end

      // One cursor step per cycle
      S_PROBE: begin
        cl = cursor_r;
        cb = budget_r;
        if (cb == '0) begin
          cl = (cursor_r == TOP_LEVEL) ? '0 : cursor_r + 1'b1;
          cb = BUDGET_W'(1) << cl;
        end
        cb = cb - 1'b1;
        cursor_nxt = cl;
        if (fill_r[cl] != '0) begin
          re    = 1'b1;
          raddr = ADDR_W'(cl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_ptr_r[cl]);
          head_ptr_nxt[cl] = (head_ptr_r[cl] == PTR_W'(FIFO_DEPTH-1)) ? '0
                             : head_ptr_r[cl] + 1'b1;
          fill_nxt[cl] = fill_r[cl] - 1'b1;
          budget_nxt = cb;
          lvl_nxt    = cl;
          state_nxt  = S_POP;
        end else begin
          budget_nxt = '0;
          probe_nxt  = probe_r + 1'b1;
          if (probe_r == PROBE_W'(NUM_LEVELS-1)) begin
            state_nxt = S_NONE;
          end
        end
      end

      S_POP: begin
        if (out_free) begin
          head_seq_nxt[lvl_r] = rdata[WORD_W-1:PID_BITS];
          out_valid_nxt = 1'b1;
          oc_nxt      = OC_DISP;
          opid_nxt    = rdata[PID_BITS-1:0];
          olvl_nxt    = lvl_r;
          oseq_nxt    = rdata[WORD_W-1:PID_BITS];
          oslice_nxt  = slice_r;
          obefore_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      S_NONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oc_nxt      = OC_NONE;
          opid_nxt    = '0;
          olvl_nxt    = '0;
          oseq_nxt    = '0;
          oslice_nxt  = '0;
          obefore_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      S_CMP_A: begin
        neg_a_nxt = d_neg;
        mag_a_nxt = d_mag;
        state_nxt = S_CMP_B;
      end

      S_CMP_B: begin
        if (out_free) begin
          gt = mag_a_r > d_mag;
          lt = mag_a_r < d_mag;
          out_valid_nxt = 1'b1;
          oc_nxt      = OC_CMP;
          opid_nxt    = '0;
          olvl_nxt    = lv;
          oseq_nxt    = '0;
          oslice_nxt  = '0;
          if (neg_a_r != d_neg) obefore_nxt = d_neg;
          else                  obefore_nxt = neg_a_r ? lt : gt;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slice_r     <= SLICE_RESET;
      cursor_r    <= '0;
      budget_r    <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_ptr_r[i] <= '0;
        fill_r[i]     <= '0;
        tail_seq_r[i] <= '0;
        head_seq_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      slice_r     <= slice_nxt;
      cursor_r    <= cursor_nxt;
      budget_r    <= budget_nxt;
      probe_r     <= probe_nxt;
      out_valid_r <= out_valid_nxt;
      head_ptr_r  <= head_ptr_nxt;
      fill_r      <= fill_nxt;
      tail_seq_r  <= tail_seq_nxt;
      head_seq_r  <= head_seq_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pid_r     <= pid_nxt;
    wa_r      <= wa_nxt;
    wb_r      <= wb_nxt;
    loc_r     <= loc_nxt;
    reenq_r   <= reenq_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    lvl_r     <= lvl_nxt;
    neg_a_r   <= neg_a_nxt;
    mag_a_r   <= mag_a_nxt;
    oc_r      <= oc_nxt;
    opid_r    <= opid_nxt;
    olvl_r    <= olvl_nxt;
    oseq_r    <= oseq_nxt;
    oslice_r  <= oslice_nxt;
    obefore_r <= obefore_nxt;
  end

`ifndef SYNTHESIS
  // cursor stays on a real level
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= TOP_LEVEL) else $error("cursor out of range");
  // budget never above the top level's share
  a_budget_range: assert property (@(posedge clk) disable iff (!rst_n)
    budget_r <= BUDGET_W'(16)) else $error("budget out of range");
  // a pop only follows a probe
  a_pop_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && $past(state_r) != S_POP) |-> $past(state_r) == S_PROBE)
    else $error("pop without probe");
  // fill of the cursor level never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[cursor_r] <= FILL_W'(FIFO_DEPTH)) else $error("fill overflow");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the weighted five-level FIFO scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import wffs_pkg::*;

  localparam int DEPTH = 4096;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    mode_t       mode;
    logic [21:0] pid;
    logic [13:0] weight;
    logic        to_local;
    logic        reenq;
    logic [31:0] seq_a;
    logic [13:0] weight_b;
    logic [31:0] seq_b;
  } task_req_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [21:0] pid;
    logic [2:0]  level;
    logic [31:0] seq;
    logic [63:0] slice;
    logic        a_before_b;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [119:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2:0] out_tuser;
  logic [127:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  always #5 clk = ~clk;

  weighted_five_fifo_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Scheduler model state
  logic [63:0] slice_len = SLICE_RESET;
  logic [21:0] slot_pid [NUM_LEVELS*DEPTH];
  logic [31:0] slot_seq [NUM_LEVELS*DEPTH];
  int unsigned head_ptr [NUM_LEVELS];
  int unsigned fill     [NUM_LEVELS];
  logic [31:0] tail_seq [NUM_LEVELS];
  logic [31:0] head_seq [NUM_LEVELS];
  int unsigned rr_level, rr_budget;

  task_req_t  pending_reqs[$];
  sched_res_t expected_results[$];
  task_req_t  cur_req;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  function automatic logic [2:0] weight_level(input logic [13:0] w);
    if (w <= 14'd25) return 3'd0;
    if (w <= 14'd50) return 3'd1;
    if (w < 14'd200) return 3'd2;
    if (w < 14'd400) return 3'd3;
    return 3'd4;
  endfunction

  // Signed queue distance from the level head, scaled by level; sign in bit 128
  function automatic logic [128:0] scaled_distance(input logic [31:0] seq,
                                                   input logic [13:0] w);
    logic [2:0]   lv;
    logic [31:0]  d;
    logic [127:0] mag;
    lv = weight_level(w);
    d = seq - head_seq[lv];
    if (d[31]) begin
      mag = {96'd0, -d} << lv;
      return {1'b1, mag};
    end else begin
      mag = {96'd0, d} << (4 - lv);
      return {1'b0, mag};
    end
  endfunction

  function automatic sched_res_t schedule_step(input task_req_t r);
    sched_res_t   res;
    logic [2:0]   lv;
    logic [128:0] da, db;
    int unsigned  pos;
    res = '{outcome: OC_NONE, default: '0};
    case (r.mode)
      MODE_ENQ: begin
        lv = weight_level(r.weight);
        res.seq = tail_seq[lv];
        tail_seq[lv] = tail_seq[lv] + 32'd1;
        res.pid = r.pid;
        res.level = lv;
        if (r.to_local) begin
          res.outcome = OC_LOCAL;
          res.slice = slice_len;
        end else if (r.reenq) begin
          res.outcome = OC_REENQ;
        end else if (fill[lv] >= DEPTH) begin
          res.outcome = OC_OVERFLOW;
          res.slice = slice_len;
        end else begin
          pos = (head_ptr[lv] + fill[lv]) % DEPTH;
          slot_pid[lv*DEPTH+pos] = r.pid;
          slot_seq[lv*DEPTH+pos] = res.seq;
          fill[lv]++;
          res.outcome = OC_QUEUED;
        end
      end
      MODE_DISP: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (rr_budget == 0) begin
            rr_level = (rr_level + 1) % NUM_LEVELS;
            rr_budget = 1 << rr_level;
          end
          rr_budget--;
          if (fill[rr_level] != 0) begin
            res.pid = slot_pid[rr_level*DEPTH+head_ptr[rr_level]];
            res.seq = slot_seq[rr_level*DEPTH+head_ptr[rr_level]];
            head_ptr[rr_level] = (head_ptr[rr_level] + 1) % DEPTH;
            fill[rr_level]--;
            head_seq[rr_level] = res.seq;
            res.outcome = OC_DISP;
            res.level = 3'(rr_level);
            res.slice = slice_len;
            break;
          end
          rr_budget = 0;
        end
      end
      MODE_CMP: begin
        res.outcome = OC_CMP;
        res.level = weight_level(r.weight);
        da = scaled_distance(r.seq_a, r.weight);
        db = scaled_distance(r.seq_b, r.weight_b);
        if (da[128] != db[128]) res.a_before_b = db[128];
        else if (da[128]) res.a_before_b = da[127:0] < db[127:0];
        else res.a_before_b = da[127:0] > db[127:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Input driver: predicts on each accepted transfer, then presents the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(schedule_step(cur_req));
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_tuser <= cur_req.mode;
          in_tdata <= {4'd0, cur_req.seq_b, cur_req.weight_b, cur_req.seq_a,
                       cur_req.reenq, cur_req.to_local, cur_req.weight, cur_req.pid};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    sched_res_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[21:0], out_tdata[24:22], out_tdata[56:25],
               out_tdata[120:57], out_tdata[121]};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[127:122] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp oc=%0d pid=%h lv=%0d seq=%h sl=%h ab=%b",
                       want.outcome, want.pid, want.level, want.seq, want.slice,
                       want.a_before_b, "\n          got oc=%0d pid=%h lv=%0d seq=%h sl=%h ab=%b",
                       got.outcome, got.pid, got.level, got.seq, got.slice, got.a_before_b);
          end
        end
      end
      out_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic task_req_t make_req(input mode_t m, input logic [21:0] pid,
                                         input logic [13:0] w, input logic loc,
                                         input logic re, input logic [31:0] sa,
                                         input logic [13:0] wb, input logic [31:0] sb);
    return '{mode: m, pid: pid, weight: w, to_local: loc, reenq: re,
             seq_a: sa, weight_b: wb, seq_b: sb};
  endfunction

  function automatic logic [13:0] rand_weight();
    case ($urandom_range(3))
      0: return 14'($urandom_range(60));
      1: return 14'($urandom_range(450));
      2: return 14'($urandom_range(10000, 1));
      default: return 14'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_seq();
    if ($urandom_range(1)) return 32'($urandom_range(200));
    return $urandom;
  endfunction

  task automatic queue_random(input int count);
    int unsigned pick;
    mode_t m;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      m = pick < 45 ? MODE_ENQ : pick < 80 ? MODE_DISP : pick < 95 ? MODE_CMP : MODE_NOP;
      pending_reqs.push_back(make_req(m, 22'($urandom), rand_weight(),
                                      $urandom_range(7) == 0, $urandom_range(7) == 0,
                                      rand_seq(), rand_weight(), rand_seq()));
    end
  endtask

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_slice(input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slice_len = value;
  endtask

  initial begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      head_ptr[l] = 0; fill[l] = 0; tail_seq[l] = '0; head_seq[l] = '0;
    end
    rr_level = 0;
    rr_budget = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles less than receiver; directed cases first
    send_idle_pct = 34;
    recv_idle_pct = 68;
    pending_reqs.push_back(make_req(MODE_DISP, '0, 14'd1, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, '0, 14'd0, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, '1, 14'd25, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h2AAAAA, 14'd26, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h155555, 14'd50, 1, 1, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h3, 14'd51, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h4, 14'd199, 0, 1, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h5, 14'd200, 1, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h6, 14'd399, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h7, 14'd400, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_ENQ, 22'h8, 14'h3FFF, 0, 0, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_CMP, '1, 14'd1, '1, 14'd10000, '0, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_CMP, '0, 14'd10000, 32'h80000000, 14'd1,
                                    32'h7FFFFFFF, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_CMP, '0, 14'h3FFF, 32'hFFFFFFFF, 14'h3FFF,
                                    32'h80000000, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_CMP, '0, 14'd0, 32'h5, 14'd30, 32'h5, 14'd1, '0));
    pending_reqs.push_back(make_req(MODE_NOP, '1, '1, 1, 1, '1, '1, '1));
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(make_req(MODE_DISP, '0, 14'd1, 0, 0, '0, 14'd1, '0));
    queue_random(250);
    wait_drained();
    write_slice('1);

    // Phase 2: receiver idles less than sender
    send_idle_pct = 68;
    recv_idle_pct = 34;
    queue_random(260);
    wait_drained();
    write_slice('0);
    queue_random(20);
    wait_drained();
    write_slice({$urandom, $urandom});

    // Phase 3: no idling; a burst of enqueues into the top level, then random traffic
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 120; i++)
      pending_reqs.push_back(make_req(MODE_ENQ, 22'($urandom), 14'(10000 - i % 8000),
                                      0, 0, '0, 14'd1, '0));
    queue_random(130);
    wait_drained();

    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

FILE: weighted_five_fifo_scheduler.f
rtl/wffs_pkg.sv
rtl/wffs_ram.sv
rtl/wffs_dist.sv
rtl/weighted_five_fifo_scheduler.sv
sim/tb_top.sv
